// File: rtl/tcce_pkg.sv
// tcce_pkg: shared constants for the text console cursor engine
// character codes, field widths and geometry defaults
// no dependencies; used by every module of the block
package tcce_pkg;

  // screen geometry defaults
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  // field widths
  localparam int CellW  = 16;
  localparam int CharW  = 8;
  localparam int ColorW = 8;
  localparam int RowFldW = 5;
  localparam int ColFldW = 7;

  // character codes
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChReturn  = 8'd13;
  localparam logic [CharW-1:0] ChTab     = 8'd9;
  localparam logic [CharW-1:0] ChBlank   = 8'h20;

  // tab stops every eight columns
  localparam int TabStep = 8;

  // attribute after reset: grey on black
  localparam logic [ColorW-1:0] ResetColor = 8'h07;

  // item kinds
  localparam logic KindPut  = 1'b0;
  localparam logic KindRead = 1'b1;

endpackage

// File: rtl/tcce_screen_ram.sv
// tcce_screen_ram: single-port screen memory, one cell per entry
// registered read data
// depends on tcce_pkg
module tcce_screen_ram #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows,
  localparam int Depth  = ROWS * COLUMNS,
  localparam int AddrW  = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [tcce_pkg::CellW-1:0] wdata_i,
  output logic [tcce_pkg::CellW-1:0] rdata_o
);

  logic [tcce_pkg::CellW-1:0] mem_q [Depth];
  logic [tcce_pkg::CellW-1:0] rdata_q;

  // write port and registered read on the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tcce_ctrl.sv
// tcce_ctrl: sequencer for the console: cursor, row ring offset,
// character decode, cell reads and the row clearing sweep
// depends on tcce_pkg; drives the port of tcce_screen_ram
module tcce_ctrl #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows,
  localparam int AddrW  = $clog2(ROWS * COLUMNS),
  localparam int RowW   = $clog2(ROWS),
  localparam int ColW   = $clog2(COLUMNS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [tcce_pkg::CharW-1:0]    char_code_i,
  input  logic [tcce_pkg::RowFldW-1:0]  read_row_i,
  input  logic [tcce_pkg::ColFldW-1:0]  read_col_i,
  input  logic [tcce_pkg::ColorW-1:0]   text_color_i,
  // memory port
  output logic                          mem_we_o,
  output logic [AddrW-1:0]              mem_addr_o,
  output logic [tcce_pkg::CellW-1:0]    mem_wdata_o,
  input  logic [tcce_pkg::CellW-1:0]    mem_rdata_i,
  // result word
  output logic                          done_o,
  output logic [tcce_pkg::CellW-1:0]    cell_value_o,
  output logic                          cell_written_o,
  output logic                          did_scroll_o,
  output logic [tcce_pkg::RowFldW-1:0]  cursor_row_o,
  output logic [tcce_pkg::ColFldW-1:0]  cursor_col_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RDATA
  } state_e;

  state_e state_q, state_d;

  // cursor (logical row) and physical row of the top line
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] top_q, top_d;

  // clearing sweep
  logic [AddrW-1:0]           clr_addr_q, clr_addr_d;
  logic [AddrW-1:0]           clr_end_q, clr_end_d;
  logic [tcce_pkg::ColorW-1:0] clr_color_q, clr_color_d;

  // result registers
  logic                         done_q, done_d;
  logic [tcce_pkg::CellW-1:0]   value_q, value_d;
  logic                         written_q, written_d;
  logic                         scroll_q, scroll_d;
  logic [tcce_pkg::RowFldW-1:0] res_row_q, res_row_d;
  logic [tcce_pkg::ColFldW-1:0] res_col_q, res_col_d;

  // latched command word
  logic                          item_kind_q;
  logic [tcce_pkg::CharW-1:0]    item_char_q;
  logic [tcce_pkg::RowFldW-1:0]  item_row_q;
  logic [tcce_pkg::ColFldW-1:0]  item_col_q;

  // decode results
  logic [RowW-1:0]            row_n;
  logic [ColW-1:0]            col_n;
  logic                       new_line;
  logic                       put_cell;
  logic                       scroll_n;
  logic                       rd_ok;
  logic [ColW:0]              col_inc;
  logic [ColW:0]              tab_pos;
  logic [AddrW-1:0]           cur_addr;
  logic [AddrW-1:0]           rd_addr;
  logic [AddrW-1:0]           top_base;
  logic [tcce_pkg::CellW-1:0] put_word;

  // logical row and column to memory address through the row ring
  function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] lr,
                                                 input logic [ColW-1:0] c,
                                                 input logic [RowW-1:0] top);
    logic [RowW:0] s;
    s = {1'b0, lr} + {1'b0, top};
    if (s >= (RowW+1)'(ROWS)) begin
      s = s - (RowW+1)'(ROWS);
    end
    return AddrW'(s) * AddrW'(COLUMNS) + AddrW'(c);
  endfunction

  // character decode and cursor advance
  always_comb begin
    col_inc  = {1'b0, col_q} + (ColW+1)'(1);
    tab_pos  = ({1'b0, col_q} + (ColW+1)'(tcce_pkg::TabStep))
               & ~((ColW+1)'(tcce_pkg::TabStep - 1));
    new_line = 1'b0;
    put_cell = 1'b0;
    scroll_n = 1'b0;
    row_n    = row_q;
    col_n    = col_q;
    unique case (item_char_q)
      tcce_pkg::ChNewline: begin
        new_line = 1'b1;
      end
      tcce_pkg::ChReturn: begin
        col_n = '0;
      end
      tcce_pkg::ChTab: begin
        if (tab_pos >= (ColW+1)'(COLUMNS)) begin
          new_line = 1'b1;
        end else begin
          col_n = tab_pos[ColW-1:0];
        end
      end
      default: begin
        put_cell = 1'b1;
        if (col_inc >= (ColW+1)'(COLUMNS)) begin
          new_line = 1'b1;
        end else begin
          col_n = col_inc[ColW-1:0];
        end
      end
    endcase
    if (new_line) begin
      col_n = '0;
      if (row_q == RowW'(ROWS - 1)) begin
        scroll_n = 1'b1;
      end else begin
        row_n = row_q + RowW'(1);
      end
    end
  end

  // addresses and the written cell
  always_comb begin
    rd_ok    = (32'(item_row_q) < ROWS) && (32'(item_col_q) < COLUMNS);
    cur_addr = cell_addr(row_q, col_q, top_q);
    rd_addr  = cell_addr(RowW'(item_row_q), ColW'(item_col_q), top_q);
    top_base = AddrW'(top_q) * AddrW'(COLUMNS);
    put_word = {text_color_i, item_char_q};
  end

  // memory port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_addr_o  = clr_addr_q;
    mem_wdata_o = {clr_color_q, tcce_pkg::ChBlank};
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
      end
      S_EXEC: begin
        if (item_kind_q == tcce_pkg::KindRead) begin
          mem_addr_o = rd_addr;
        end else begin
          mem_addr_o  = cur_addr;
          mem_wdata_o = put_word;
          mem_we_o    = put_cell;
        end
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    top_d       = top_q;
    clr_addr_d  = clr_addr_q;
    clr_end_d   = clr_end_q;
    clr_color_d = clr_color_q;
    done_d      = 1'b0;
    value_d     = value_q;
    written_d   = written_q;
    scroll_d    = scroll_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == clr_end_q) begin
          state_d = S_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AddrW'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_kind_q == tcce_pkg::KindRead) begin
          written_d = 1'b0;
          scroll_d  = 1'b0;
          res_row_d = tcce_pkg::RowFldW'(row_q);
          res_col_d = tcce_pkg::ColFldW'(col_q);
          if (rd_ok) begin
            state_d = S_RDATA;
          end else begin
            value_d = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          row_d     = row_n;
          col_d     = col_n;
          value_d   = put_cell ? put_word : '0;
          written_d = put_cell;
          scroll_d  = scroll_n;
          res_row_d = tcce_pkg::RowFldW'(row_n);
          res_col_d = tcce_pkg::ColFldW'(col_n);
          done_d    = 1'b1;
          if (scroll_n) begin
            // old top line becomes the new bottom line, blank it
            top_d       = (top_q == RowW'(ROWS - 1)) ? '0 : top_q + RowW'(1);
            clr_addr_d  = top_base;
            clr_end_d   = top_base + AddrW'(COLUMNS - 1);
            clr_color_d = text_color_i;
            state_d     = S_CLEAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RDATA: begin
        value_d = mem_rdata_i;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs; reset starts the full-screen sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      clr_addr_q  <= '0;
      clr_end_q   <= AddrW'(ROWS * COLUMNS - 1);
      clr_color_q <= tcce_pkg::ResetColor;
      done_q      <= 1'b0;
      value_q     <= '0;
      written_q   <= 1'b0;
      scroll_q    <= 1'b0;
      res_row_q   <= '0;
      res_col_q   <= '0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      top_q       <= top_d;
      clr_addr_q  <= clr_addr_d;
      clr_end_q   <= clr_end_d;
      clr_color_q <= clr_color_d;
      done_q      <= done_d;
      value_q     <= value_d;
      written_q   <= written_d;
      scroll_q    <= scroll_d;
      res_row_q   <= res_row_d;
      res_col_q   <= res_col_d;
    end
  end

  // command word capture
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      item_kind_q <= kind_i;
      item_char_q <= char_code_i;
      item_row_q  <= read_row_i;
      item_col_q  <= read_col_i;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign cell_value_o   = value_q;
  assign cell_written_o = written_q;
  assign did_scroll_o   = scroll_q;
  assign cursor_row_o   = res_row_q;
  assign cursor_col_o   = res_col_q;

endmodule

// File: rtl/text_console_cursor_engine.sv
// text_console_cursor_engine: top level of the text console
// holds the color register, connects tcce_ctrl to tcce_screen_ram
// depends on tcce_pkg, tcce_ctrl, tcce_screen_ram
//
// Usage:
//   Command channel: a word is taken at a clock edge with start_i high and
//   busy_o low. kind_i selects a character put or a cell read.
//   Result: done_o is high for exactly one cycle with the result word on
//   cell_value_o, cell_written_o, did_scroll_o, cursor_row_o, cursor_col_o.
//   The receiver cannot stall; the result is gone after that cycle.
//   Sequence: a put passes S_EXEC; when done_o rises for a put that does not
//   scroll, busy_o is low and the next word may follow; an in-range read also passes S_RDATA.
//   A put that scrolls stays busy while the single memory port blanks one row;
//   rows live in a ring, so no data is copied.
//   Config channel: cfg_data_i is the attribute byte, taken when
//   cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high.
//   Write it only while idle.
//   Reset: cursor goes home, color becomes grey on black, and the block stays
//   busy while it blanks the whole screen, one cell per cycle.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [tcce_pkg::CharW-1:0]    char_code_i,
  input  logic [tcce_pkg::RowFldW-1:0]  read_row_i,
  input  logic [tcce_pkg::ColFldW-1:0]  read_col_i,
  // result word
  output logic                          done_o,
  output logic [tcce_pkg::CellW-1:0]    cell_value_o,
  output logic                          cell_written_o,
  output logic                          did_scroll_o,
  output logic [tcce_pkg::RowFldW-1:0]  cursor_row_o,
  output logic [tcce_pkg::ColFldW-1:0]  cursor_col_o,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcce_pkg::ColorW-1:0]   cfg_data_i
);

  localparam int AddrW = $clog2(ROWS * COLUMNS);

  logic [tcce_pkg::ColorW-1:0] text_color_q;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_addr;
  logic [tcce_pkg::CellW-1:0]  mem_wdata;
  logic [tcce_pkg::CellW-1:0]  mem_rdata;

  // attribute register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcce_pkg::ResetColor;
    end else if (cfg_valid_i && cfg_ready_o) begin
      text_color_q <= cfg_data_i;
    end
  end

  // sequencer
  tcce_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .char_code_i    (char_code_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .text_color_i   (text_color_q),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .done_o         (done_o),
    .cell_value_o   (cell_value_o),
    .cell_written_o (cell_written_o),
    .did_scroll_o   (did_scroll_o),
    .cursor_row_o   (cursor_row_o),
    .cursor_col_o   (cursor_col_o)
  );

  // screen memory
  tcce_screen_ram #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// File: test/console_checker.sv
// console_checker: watches the command, result and attribute channels of the
// text console, predicts each result word and compares it field by field
// depends on tcce_pkg; instantiated by tb beside the block
module console_checker #(
  parameter int COLUMNS = tcce_pkg::DefColumns,
  parameter int ROWS    = tcce_pkg::DefRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          kind_i,
  input  logic [tcce_pkg::CharW-1:0]    char_code_i,
  input  logic [tcce_pkg::RowFldW-1:0]  read_row_i,
  input  logic [tcce_pkg::ColFldW-1:0]  read_col_i,
  // result word
  input  logic                          done_i,
  input  logic [tcce_pkg::CellW-1:0]    cell_value_i,
  input  logic                          cell_written_i,
  input  logic                          did_scroll_i,
  input  logic [tcce_pkg::RowFldW-1:0]  cursor_row_i,
  input  logic [tcce_pkg::ColFldW-1:0]  cursor_col_i,
  // attribute channel
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [tcce_pkg::ColorW-1:0]   cfg_data_i,
  // status for the top
  output int                            fail_count_o,
  output int                            words_in_flight_o,
  output int                            scrolls_seen_o
);
  import tcce_pkg::*;

  typedef struct packed {
    logic [CellW-1:0]   value;
    logic               written;
    logic               scrolled;
    logic [RowFldW-1:0] row;
    logic [ColFldW-1:0] col;
  } console_word_t;

  // shadow copy of the screen, cursor and attribute
  logic [CellW-1:0]  shadow_screen [ROWS*COLUMNS];
  logic [ColorW-1:0] shadow_color;
  int                shadow_row;
  int                shadow_col;

  console_word_t expected_words[$];
  int            mismatches;
  int            scrolls;

  assign fail_count_o      = mismatches;
  assign words_in_flight_o = expected_words.size();
  assign scrolls_seen_o    = scrolls;

  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  // move to column 0 of the next row, scrolling up from the bottom row
  function automatic logic line_feed();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      shadow_row = ROWS - 1;
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        shadow_screen[i] = shadow_screen[i + COLUMNS];
      end
      for (int i = 0; i < COLUMNS; i++) begin
        shadow_screen[(ROWS - 1) * COLUMNS + i] = {shadow_color, ChBlank};
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one command to the shadow state and build its result word
  function automatic console_word_t advance_console(
    input logic               kind,
    input logic [CharW-1:0]   code,
    input logic [RowFldW-1:0] rd_row,
    input logic [ColFldW-1:0] rd_col
  );
    console_word_t w;
    w = '0;
    if (kind == KindRead) begin
      if (int'(rd_row) < ROWS && int'(rd_col) < COLUMNS) begin
        w.value = shadow_screen[int'(rd_row) * COLUMNS + int'(rd_col)];
      end
    end else if (code == ChNewline) begin
      w.scrolled = line_feed();
    end else if (code == ChReturn) begin
      shadow_col = 0;
    end else if (code == ChTab) begin
      shadow_col = (shadow_col + TabStep) & ~(TabStep - 1);
      if (shadow_col >= COLUMNS) w.scrolled = line_feed();
    end else begin
      w.value = {shadow_color, code};
      w.written = 1'b1;
      shadow_screen[shadow_row * COLUMNS + shadow_col] = w.value;
      shadow_col++;
      if (shadow_col >= COLUMNS) w.scrolled = line_feed();
    end
    w.row = RowFldW'(shadow_row);
    w.col = ColFldW'(shadow_col);
    return w;
  endfunction

  // results first, then attribute writes, then newly taken commands
  always @(posedge clk_i or negedge rst_ni) begin
    console_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ROWS * COLUMNS; i++) shadow_screen[i] = {ResetColor, ChBlank};
      shadow_color = ResetColor;
      shadow_row   = 0;
      shadow_col   = 0;
      expected_words.delete();
      mismatches   = 0;
      scrolls      = 0;
    end else begin
      if (done_i) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("result word with nothing pending", 0, int'(cell_value_i));
        end else begin
          want = expected_words.pop_front();
          if (cell_value_i !== want.value)
            flag_mismatch("cell_value", int'(want.value), int'(cell_value_i));
          if (cell_written_i !== want.written)
            flag_mismatch("cell_written", int'(want.written), int'(cell_written_i));
          if (did_scroll_i !== want.scrolled)
            flag_mismatch("did_scroll", int'(want.scrolled), int'(did_scroll_i));
          if (cursor_row_i !== want.row)
            flag_mismatch("cursor_row", int'(want.row), int'(cursor_row_i));
          if (cursor_col_i !== want.col)
            flag_mismatch("cursor_col", int'(want.col), int'(cursor_col_i));
          if (want.scrolled) scrolls++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) shadow_color = cfg_data_i;
      if (start_i && !busy_i) begin
        expected_words.push_back(advance_console(kind_i, char_code_i, read_row_i, read_col_i));
      end
    end
  end

endmodule

// File: test/tb.sv
// tb: stimulus and verdict for text_console_cursor_engine
// directed edge cases, then random characters, tabs, newlines, returns and cell reads
// depends on tcce_pkg, text_console_cursor_engine and console_checker
module tb;
  import tcce_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               kind_i;
  logic [CharW-1:0]   char_code_i;
  logic [RowFldW-1:0] read_row_i;
  logic [ColFldW-1:0] read_col_i;
  logic               done_o;
  logic [CellW-1:0]   cell_value_o;
  logic               cell_written_o;
  logic               did_scroll_o;
  logic [RowFldW-1:0] cursor_row_o;
  logic [ColFldW-1:0] cursor_col_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [ColorW-1:0]  cfg_data_i;

  int fail_count;
  int words_in_flight;
  int scrolls_seen;
  int commands_sent;
  int reads_sent;
  int colors_used;

  always #1 clk_i = ~clk_i;

  text_console_cursor_engine uut (
    .clk_i, .rst_ni,
    .start_i, .busy_o, .kind_i, .char_code_i, .read_row_i, .read_col_i,
    .done_o, .cell_value_o, .cell_written_o, .did_scroll_o, .cursor_row_o, .cursor_col_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  console_checker u_checker (
    .clk_i, .rst_ni,
    .start_i, .busy_i(busy_o), .kind_i, .char_code_i, .read_row_i, .read_col_i,
    .done_i(done_o), .cell_value_i(cell_value_o), .cell_written_i(cell_written_o),
    .did_scroll_i(did_scroll_o), .cursor_row_i(cursor_row_o), .cursor_col_i(cursor_col_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .words_in_flight_o(words_in_flight),
    .scrolls_seen_o(scrolls_seen)
  );

  // present one command word and return at the edge that takes it
  task automatic issue_command(input logic kind, input logic [CharW-1:0] code,
                               input logic [RowFldW-1:0] rd_row,
                               input logic [ColFldW-1:0] rd_col);
    start_i     <= 1'b1;
    kind_i      <= kind;
    char_code_i <= code;
    read_row_i  <= rd_row;
    read_col_i  <= rd_col;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    commands_sent++;
    if (kind == KindRead) reads_sent++;
  endtask

  task automatic put_char(input logic [CharW-1:0] code);
    issue_command(KindPut, code, RowFldW'($urandom), ColFldW'($urandom));
  endtask

  task automatic read_cell(input int rd_row, input int rd_col);
    issue_command(KindRead, CharW'($urandom), RowFldW'(rd_row), ColFldW'(rd_col));
  endtask

  // drop start and wait until no result is due and any row blanking is over
  task automatic wait_until_quiet(input int max_cycles);
    start_i <= 1'b0;
    for (int i = 0; i < max_cycles; i++) begin
      @(posedge clk_i);
      if (words_in_flight == 0 && !busy_o) break;
    end
  endtask

  task automatic write_color(input logic [ColorW-1:0] color);
    wait_until_quiet(5000);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= color;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    colors_used++;
  endtask

  // random command: half random bytes of any value, the rest line controls and reads
  task automatic random_command();
    int roll;
    int rd_row;
    int rd_col;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      put_char(CharW'($urandom_range(0, 255)));
    end else if (roll < 60) begin
      put_char(ChNewline);
    end else if (roll < 64) begin
      put_char(ChReturn);
    end else if (roll < 75) begin
      put_char(ChTab);
    end else begin
      rd_row = ($urandom_range(0, 9) < 8) ? $urandom_range(0, DefRows - 1) : $urandom_range(0, 31);
      rd_col = ($urandom_range(0, 9) < 8) ? $urandom_range(0, DefColumns - 1)
                                          : $urandom_range(0, 127);
      read_cell(rd_row, rd_col);
    end
  endtask

  initial begin
    int idle_pct;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    kind_i        = KindPut;
    char_code_i   = '0;
    read_row_i    = '0;
    read_col_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    commands_sent = 0;
    reads_sent    = 0;
    colors_used   = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cleared screen, out-of-range reads, odd bytes, tab stops
    read_cell(0, 0);
    read_cell(DefRows - 1, DefColumns - 1);
    read_cell(DefRows, 0);
    read_cell(0, DefColumns);
    read_cell(31, 127);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    read_cell(0, 0);
    read_cell(0, 2);
    put_char(ChTab);
    put_char(ChReturn);
    // ten tabs from column 0 run off the right edge onto the next row
    repeat (10) put_char(ChTab);
    put_char(ChNewline);
    put_char(8'h7A);
    read_cell(2, 0);

    // random phases, each under its own attribute, extremes first
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) write_color(8'hFF);
      else if (phase == 1) write_color(8'h00);
      else write_color(ColorW'($urandom_range(0, 255)));
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (phase == 7) idle_pct = 0;
      for (int n = 0; n < 91; n++) begin
        random_command();
        if ($urandom_range(0, 99) < idle_pct) begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 9)) @(posedge clk_i);
        end
      end
    end

    // drain, then keep the clock running for stray result words
    wait_until_quiet(20000);
    repeat (10) @(posedge clk_i);

    $display("covered %0d commands (%0d cell reads) under %0d attribute settings",
             commands_sent, reads_sent, colors_used);
    $display("%0d scrolls checked, %0d result words still pending",
             scrolls_seen, words_in_flight);
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #1000000;
    $display("timeout with %0d result words pending", words_in_flight);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/tcce_pkg.sv
rtl/tcce_screen_ram.sv
rtl/tcce_ctrl.sv
rtl/text_console_cursor_engine.sv
test/console_checker.sv
test/tb.sv
